>>> design/bfm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfm_pkg
// shared types and constants of the bitap fuzzy line matcher
// ----------------------------------------------------------------------------
package bfm_pkg;

  localparam int MAX_PATTERN    = 31;
  localparam int MAX_ERROR_ROWS = 16;
  localparam int POSITION_BITS  = 15;

  localparam int ROW_W     = 32;
  localparam int LEN_W     = 5;
  localparam int ERR_W     = 4;
  localparam int BYTE_W    = 8;
  localparam int POS_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 64;
  localparam int CFG_BYTES = CFG_DAT_W / BYTE_W;
  localparam int TOP_BYTES = MAX_PATTERN - 3 * CFG_BYTES;

  localparam logic [ROW_W-1:0]         ROW_RESET = ~ROW_W'(1);
  localparam logic [POS_W-1:0]         POS_LIMIT = '1;
  localparam logic [POSITION_BITS-1:0] START_MAX = '1;

  typedef logic [ROW_W-1:0]                       row_t;
  typedef row_t [MAX_ERROR_ROWS-1:0]              row_bank_t;
  typedef logic [MAX_PATTERN-1:0][BYTE_W-1:0]     pattern_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_LOW  = 3'd0,
    CFG_PAT_MID  = 3'd1,
    CFG_PAT_HIGH = 3'd2,
    CFG_PAT_TOP  = 3'd3,
    CFG_PAT_LEN  = 3'd4,
    CFG_MAX_ERR  = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [ERR_W-1:0] err_top;
  } match_cfg_t;

endpackage

>>> design/bfm_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfm_core
// byte mask and one parallel update of all active error rows
// ----------------------------------------------------------------------------
module bfm_core import bfm_pkg::*; (
  input  row_bank_t         rows_cur,
  input  pattern_t          pattern,
  input  match_cfg_t        mcfg,
  input  logic [BYTE_W-1:0] text_byte,
  output row_bank_t         rows_upd,
  output logic              row_hit
);

  row_t mask;
  row_t step [MAX_ERROR_ROWS];

  always_comb begin
    mask = '1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if ((LEN_W'(i) < mcfg.len) && (pattern[i] == text_byte)) begin
        mask[i] = 1'b0;
      end
    end
  end

  always_comb begin
    for (int d = 0; d < MAX_ERROR_ROWS; d++) begin
      if (d == 0) begin
        step[d] = (rows_cur[d] | mask) << 1;
      end else begin
        step[d] = (rows_cur[d-1] & (rows_cur[d] | mask)) << 1;
      end
      rows_upd[d] = (ERR_W'(d) <= mcfg.err_top) ? step[d] : rows_cur[d];
    end
  end

  assign row_hit = ~rows_upd[mcfg.err_top][mcfg.len];

endmodule

>>> design/bitap_fuzzy_line_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitap_fuzzy_line_matcher
// mismatch-tolerant shift-or search over a byte stream split into lines
// ----------------------------------------------------------------------------
// latency: the result is valid in the cycle after the input transfer
// throughput: one byte per cycle while in_stall is low, set by the combinational row update loop
// reset: synchronous, clears pattern registers, error rows and line state
// ----------------------------------------------------------------------------
module bitap_fuzzy_line_matcher import bfm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DAT_W-1:0]     cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [BYTE_W-1:0]        in_text_byte,
  input  logic                     in_line_end,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_hit,
  output logic [POSITION_BITS-1:0] out_match_start,
  output logic                     out_line_done,
  output logic                     out_line_matched
);

  pattern_t         pattern_r;
  match_cfg_t       mcfg_r;
  row_bank_t        rows_r, rows_nxt, rows_upd;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             seen_r, seen_nxt;
  logic             row_hit;
  logic             accept;
  logic             empty_pat;

  logic                     out_valid_r;
  logic                     hit_r, hit_nxt;
  logic [POSITION_BITS-1:0] start_r, start_nxt;
  logic                     done_r;
  logic                     matched_r, matched_nxt;
  logic [POS_W:0]           pos_inc;
  logic [POS_W:0]           diff;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign empty_pat = (mcfg_r.len == '0);

  bfm_core u_core (
    .rows_cur  (rows_r),
    .pattern   (pattern_r),
    .mcfg      (mcfg_r),
    .text_byte (in_text_byte),
    .rows_upd  (rows_upd),
    .row_hit   (row_hit)
  );

  // start offset of a hit at the current byte
  always_comb begin
    pos_inc = {1'b0, pos_r} + (POS_W+1)'(1);
    diff    = pos_inc - (POS_W+1)'(mcfg_r.len);
    if (pos_r >= POS_LIMIT) begin
      start_nxt = START_MAX;
    end else if (pos_inc < (POS_W+1)'(mcfg_r.len)) begin
      start_nxt = '0;
    end else if (diff > (POS_W+1)'(START_MAX)) begin
      start_nxt = START_MAX;
    end else begin
      start_nxt = diff[POSITION_BITS-1:0];
    end
  end

  always_comb begin
    rows_nxt    = rows_r;
    pos_nxt     = pos_r;
    seen_nxt    = seen_r;
    hit_nxt     = 1'b0;
    matched_nxt = 1'b0;
    if (in_line_end) begin
      hit_nxt     = ~seen_r & empty_pat;
      matched_nxt = seen_r | empty_pat;
      seen_nxt    = 1'b0;
      pos_nxt     = '0;
      for (int d = 0; d < MAX_ERROR_ROWS; d++) begin
        rows_nxt[d] = ROW_RESET;
      end
    end else begin
      if (!seen_r) begin
        if (empty_pat) begin
          hit_nxt  = 1'b1;
          seen_nxt = 1'b1;
        end else begin
          rows_nxt = rows_upd;
          hit_nxt  = row_hit;
          seen_nxt = row_hit;
        end
      end
      if (pos_r < POS_LIMIT) begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      mcfg_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PAT_LOW: begin
          for (int j = 0; j < CFG_BYTES; j++) begin
            pattern_r[j] <= cfg_data[j*BYTE_W +: BYTE_W];
          end
        end
        CFG_PAT_MID: begin
          for (int j = 0; j < CFG_BYTES; j++) begin
            pattern_r[CFG_BYTES + j] <= cfg_data[j*BYTE_W +: BYTE_W];
          end
        end
        CFG_PAT_HIGH: begin
          for (int j = 0; j < CFG_BYTES; j++) begin
            pattern_r[2*CFG_BYTES + j] <= cfg_data[j*BYTE_W +: BYTE_W];
          end
        end
        CFG_PAT_TOP: begin
          for (int j = 0; j < TOP_BYTES; j++) begin
            pattern_r[3*CFG_BYTES + j] <= cfg_data[j*BYTE_W +: BYTE_W];
          end
        end
        CFG_PAT_LEN: mcfg_r.len     <= cfg_data[LEN_W-1:0];
        CFG_MAX_ERR: mcfg_r.err_top <= cfg_data[ERR_W-1:0];
        default: ;
      endcase
    end
  end

  // line state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < MAX_ERROR_ROWS; d++) begin
        rows_r[d] <= ROW_RESET;
      end
      pos_r       <= '0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        rows_r      <= rows_nxt;
        pos_r       <= pos_nxt;
        seen_r      <= seen_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // empty pattern hits always report offset zero
  always_ff @(posedge clk) begin
    if (accept) begin
      hit_r     <= hit_nxt;
      start_r   <= (hit_nxt && !in_line_end && !empty_pat) ? start_nxt : '0;
      done_r    <= in_line_end;
      matched_r <= matched_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = hit_r;
  assign out_match_start  = start_r;
  assign out_line_done    = done_r;
  assign out_line_matched = matched_r;

`ifndef NO_ASSERTIONS
  a_matched_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !done_r |-> !matched_r)
    else $error("line_matched without line_done");

  a_start_zero_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !hit_r |-> (start_r == '0))
    else $error("match_start set without hit");

  a_line_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_line_end |=> (pos_r == '0) && !seen_r)
    else $error("line state not cleared at line end");

  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    accept && seen_r && !in_line_end |=> !hit_r)
    else $error("second hit in one line");

  a_result_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("no result after input transfer");
`endif

endmodule

>>> tb/sv/bitap_fuzzy_line_matcher_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitap_fuzzy_line_matcher_tb
// streams text lines through the matcher and checks every per-byte report
// against a shift-or predictor in step with each input transfer or a known
// row result; a short directed table comes first, then random patterns,
// error budgets and lines built around noisy pattern copies, then longer lines
// ----------------------------------------------------------------------------
module bitap_fuzzy_line_matcher_tb;
  import bfm_pkg::*;

  localparam int QUIET_LIMIT   = 1000;
  localparam int DIRECTED_ROWS = 31;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 115;

  typedef struct packed {
    logic                     hit;
    logic [POSITION_BITS-1:0] start;
    logic                     done;
    logic                     matched;
  } match_report_t;

  typedef enum logic [1:0] {
    ROW_REG,
    ROW_TEXT,
    ROW_KNOWN
  } row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    cfg_idx_t              idx;
    logic [CFG_DAT_W-1:0]  data;
    logic [BYTE_W-1:0]     ch;
    logic                  eol;
    match_report_t         want;
  } script_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DAT_W-1:0]     cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [BYTE_W-1:0]        in_text_byte = '0;
  logic                     in_line_end = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     out_hit;
  logic [POSITION_BITS-1:0] out_match_start;
  logic                     out_line_done;
  logic                     out_line_matched;

  // predictor copy of registers and line state
  logic [CFG_DAT_W-1:0] pat_reg [4];
  logic [LEN_W-1:0]     pat_len;
  logic [ERR_W-1:0]     err_top;
  row_t                 err_rows [MAX_ERROR_ROWS];
  logic [POS_W-1:0]     line_pos;
  logic                 line_hit;

  match_report_t pending_reports [$];
  script_row_t   directed_rows [DIRECTED_ROWS];
  logic [BYTE_W-1:0] alphabet [4];
  bit            idle_en = 1'b1;
  int            stall_left = 0;
  int            mismatches = 0;
  int            item_count = 0;

  bitap_fuzzy_line_matcher uut (
    .clk,
    .rst_n,
    .cfg_valid,
    .cfg_ready,
    .cfg_index,
    .cfg_data,
    .in_valid,
    .in_stall,
    .in_text_byte,
    .in_line_end,
    .out_valid,
    .out_stall,
    .out_hit,
    .out_match_start,
    .out_line_done,
    .out_line_matched
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [BYTE_W-1:0] pat_byte(int unsigned j);
    return pat_reg[j / CFG_BYTES][BYTE_W * (j % CFG_BYTES) +: BYTE_W];
  endfunction

  function automatic void clear_line_state();
    for (int d = 0; d < MAX_ERROR_ROWS; d++) err_rows[d] = ROW_RESET;
    line_pos = '0;
    line_hit = 1'b0;
  endfunction

  function automatic match_report_t advance_matcher(logic [BYTE_W-1:0] b, logic eol);
    match_report_t r;
    int unsigned   m, k, s, i, d;
    row_t          mask, prev, old;
    r = '0;
    m = pat_len;
    k = err_top;
    if (eol) begin
      if (!line_hit && m == 0) begin
        r.hit = 1'b1;
        line_hit = 1'b1;
      end
      r.done = 1'b1;
      r.matched = line_hit;
      clear_line_state();
    end else begin
      if (!line_hit) begin
        if (m == 0) begin
          r.hit = 1'b1;
          line_hit = 1'b1;
        end else begin
          mask = '1;
          for (i = 0; i < m; i++) if (pat_byte(i) == b) mask[i] = 1'b0;
          prev = err_rows[0];
          err_rows[0] = (err_rows[0] | mask) << 1;
          for (d = 1; d <= k; d++) begin
            old = err_rows[d];
            err_rows[d] = (prev & (old | mask)) << 1;
            prev = old;
          end
          if (!err_rows[k][m]) begin
            r.hit = 1'b1;
            line_hit = 1'b1;
            if (line_pos >= POS_LIMIT) s = START_MAX;
            else if (line_pos + 1 >= m) s = line_pos + 1 - m;
            else s = 0;
            if (s > START_MAX) s = START_MAX;
            r.start = POSITION_BITS'(s);
          end
        end
      end
      if (line_pos < POS_LIMIT) line_pos++;
    end
    return r;
  endfunction

  function automatic logic [BYTE_W-1:0] noise_byte();
    return ($urandom_range(0, 9) < 7) ? alphabet[$urandom_range(0, 3)]
                                      : BYTE_W'($urandom_range(0, 255));
  endfunction

  function automatic script_row_t reg_row(cfg_idx_t idx, logic [CFG_DAT_W-1:0] data);
    script_row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  function automatic script_row_t text_row(logic [BYTE_W-1:0] ch, logic eol);
    script_row_t r;
    r = '0;
    r.kind = ROW_TEXT;
    r.ch = ch;
    r.eol = eol;
    return r;
  endfunction

  function automatic script_row_t known_row(logic [BYTE_W-1:0] ch, logic eol, logic hit,
                                            int unsigned start, logic done, logic matched);
    script_row_t r;
    r = '0;
    r.kind = ROW_KNOWN;
    r.ch = ch;
    r.eol = eol;
    r.want.hit = hit;
    r.want.start = POSITION_BITS'(start);
    r.want.done = done;
    r.want.matched = matched;
    return r;
  endfunction

  task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic send_byte(logic [BYTE_W-1:0] b, logic eol, bit use_known,
                           match_report_t known);
    match_report_t r;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_text_byte <= b;
    in_line_end <= eol;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = advance_matcher(b, eol);
    pending_reports = {pending_reports, (use_known ? known : r)};
    item_count++;
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_PAT_LOW, CFG_PAT_MID, CFG_PAT_HIGH: pat_reg[idx] = data;
      CFG_PAT_TOP: begin
        pat_reg[idx] = data;
        pat_reg[idx][CFG_DAT_W-1:TOP_BYTES*BYTE_W] = '0;
      end
      CFG_PAT_LEN: pat_len = data[LEN_W-1:0];
      CFG_MAX_ERR: err_top = data[ERR_W-1:0];
      default: ;
    endcase
  endtask

  // all results in, then let the pipeline settle
  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_matcher(logic [CFG_DAT_W-1:0] lo, logic [CFG_DAT_W-1:0] mid,
                                 logic [CFG_DAT_W-1:0] hi, logic [CFG_DAT_W-1:0] top,
                                 int unsigned len, int unsigned err);
    logic [CFG_DAT_W-1:0] junk;
    write_reg(CFG_PAT_LOW, lo);
    write_reg(CFG_PAT_MID, mid);
    write_reg(CFG_PAT_HIGH, hi);
    write_reg(CFG_PAT_TOP, top);
    junk = {$urandom, $urandom};
    write_reg(CFG_PAT_LEN, {junk[CFG_DAT_W-1:LEN_W], LEN_W'(len)});
    junk = {$urandom, $urandom};
    write_reg(CFG_MAX_ERR, {junk[CFG_DAT_W-1:ERR_W], ERR_W'(err)});
    cfg_valid <= 1'b0;
  endtask

  // noisy copies of the pattern mixed with filler, then the end marker
  task automatic send_random_line();
    logic [BYTE_W-1:0] line_bytes [$];
    int unsigned       m, len, sub_odds, j;
    m = pat_len;
    len = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, m + m / 2 + 6);
    sub_odds = $urandom_range(0, 4);
    while (line_bytes.size() < len) begin
      if (m != 0 && $urandom_range(0, 2) == 0) begin
        for (j = 0; j < m; j++)
          line_bytes = {line_bytes,
                        (($urandom_range(0, 15) < sub_odds) ? noise_byte() : pat_byte(j))};
      end else begin
        line_bytes = {line_bytes, noise_byte()};
      end
    end
    foreach (line_bytes[i]) send_byte(line_bytes[i], 1'b0, 1'b0, '0);
    send_byte(noise_byte(), 1'b1, 1'b0, '0);
  endtask

  task automatic send_long_line(int unsigned filler);
    repeat (filler) send_byte(8'h2E, 1'b0, 1'b0, '0);
    for (int j = 0; j < 4; j++) send_byte(pat_byte(j), 1'b0, 1'b0, '0);
    send_byte(8'h2E, 1'b1, 1'b0, '0);
  endtask

  always @(posedge clk) begin : result_check
    match_report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result hit=%0d start=%0d done=%0d matched=%0d", $time,
                 out_hit, out_match_start, out_line_done, out_line_matched);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        compare_field("hit", 16'(want.hit), 16'(out_hit));
        compare_field("match_start", 16'(want.start), 16'(out_match_start));
        compare_field("line_done", 16'(want.done), 16'(out_line_done));
        compare_field("line_matched", 16'(want.matched), 16'(out_line_matched));
      end
    end
    if (!idle_en) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      if (stall_left == 0) out_stall <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 18);
      out_stall <= 1'b1;
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("bitap_fuzzy_line_matcher_tb: errors");
    $finish;
  end

  initial begin : stimulus
    int                   i, phase, base;
    int unsigned          len, err;
    bit                   cfg_open;
    logic [CFG_DAT_W-1:0] regs [4];
    for (i = 0; i < 4; i++) pat_reg[i] = '0;
    pat_len = '0;
    err_top = '0;
    clear_line_state();
    cfg_open = 1'b0;

    directed_rows = '{
      known_row(8'h61, 1'b0, 1'b1, 0, 1'b0, 1'b0),
      known_row(8'hFF, 1'b0, 1'b0, 0, 1'b0, 1'b0),
      known_row(8'h00, 1'b1, 1'b0, 0, 1'b1, 1'b1),
      known_row(8'h00, 1'b1, 1'b1, 0, 1'b1, 1'b1),
      reg_row(CFG_PAT_LOW, 64'h0000_0000_0063_6261),
      reg_row(CFG_PAT_LEN, 64'd3),
      reg_row(CFG_MAX_ERR, 64'd0),
      text_row(8'h61, 1'b0),
      text_row(8'h62, 1'b0),
      known_row(8'h63, 1'b0, 1'b1, 0, 1'b0, 1'b0),
      known_row(8'h00, 1'b1, 1'b0, 0, 1'b1, 1'b1),
      text_row(8'h78, 1'b0),
      text_row(8'h61, 1'b0),
      text_row(8'h62, 1'b0),
      text_row(8'h64, 1'b0),
      known_row(8'h00, 1'b1, 1'b0, 0, 1'b1, 1'b0),
      reg_row(CFG_MAX_ERR, 64'd1),
      text_row(8'h78, 1'b0),
      text_row(8'h61, 1'b0),
      text_row(8'h62, 1'b0),
      text_row(8'h64, 1'b0),
      text_row(8'h00, 1'b1),
      reg_row(CFG_PAT_LOW, 64'h0000_0000_0000_00FF),
      reg_row(CFG_PAT_LEN, 64'd1),
      reg_row(CFG_MAX_ERR, 64'd0),
      known_row(8'h00, 1'b0, 1'b0, 0, 1'b0, 1'b0),
      known_row(8'hFF, 1'b0, 1'b1, 1, 1'b0, 1'b0),
      known_row(8'hFF, 1'b1, 1'b0, 0, 1'b1, 1'b1),
      reg_row(CFG_MAX_ERR, 64'hF),
      text_row(8'h00, 1'b0),
      text_row(8'h00, 1'b1)
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (i = 0; i < DIRECTED_ROWS; i++) begin
      if (directed_rows[i].kind == ROW_REG) begin
        if (!cfg_open) begin
          quiesce();
          cfg_open = 1'b1;
        end
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        if (cfg_open) begin
          cfg_valid <= 1'b0;
          cfg_open = 1'b0;
        end
        send_byte(directed_rows[i].ch, directed_rows[i].eol,
                  directed_rows[i].kind == ROW_KNOWN, directed_rows[i].want);
      end
    end

    // random patterns and lines
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      idle_en = (phase < RANDOM_PHASES - 2) && ($urandom_range(0, 3) != 0);
      for (i = 0; i < 4; i++) alphabet[i] = BYTE_W'($urandom_range(0, 255));
      if (phase % 2 == 0) begin
        alphabet[0] = 8'h00;
        alphabet[1] = 8'hFF;
      end
      for (i = 0; i < 4; i++) regs[i] = {$urandom, $urandom};
      for (i = 0; i < MAX_PATTERN; i++)
        regs[i / CFG_BYTES][BYTE_W * (i % CFG_BYTES) +: BYTE_W] =
          ($urandom_range(0, 3) == 0) ? BYTE_W'($urandom_range(0, 255))
                                      : alphabet[$urandom_range(0, 3)];
      case (phase)
        0: begin
          len = MAX_PATTERN;
          err = MAX_ERROR_ROWS - 1;
        end
        1: begin
          len = MAX_PATTERN;
          err = 0;
        end
        2: begin
          len = 0;
          err = $urandom_range(0, MAX_ERROR_ROWS - 1);
        end
        3: begin
          len = 1;
          err = 0;
        end
        default: begin
          len = $urandom_range(2, MAX_PATTERN);
          case ($urandom_range(0, 3))
            0: err = len / 2;
            1: err = 0;
            2: err = MAX_ERROR_ROWS - 1;
            default: err = $urandom_range(0, MAX_ERROR_ROWS - 1);
          endcase
        end
      endcase
      quiesce();
      program_matcher(regs[0], regs[1], regs[2], regs[3], len, err);
      base = item_count;
      while (item_count - base < PHASE_ITEMS) send_random_line();
    end

    // longer lines: filler ahead of the pattern
    idle_en = 1'b0;
    quiesce();
    program_matcher(64'h0000_0000_5A59_5857, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, 4, 0);
    send_long_line(12);
    send_long_line(24);

    quiesce();
    if (mismatches == 0) begin
      $display("bitap_fuzzy_line_matcher_tb: clean");
    end else begin
      $display("bitap_fuzzy_line_matcher_tb: errors");
    end
    $finish;
  end

endmodule
